// ----- hw/rtl/mjq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mjq_pkg;

  localparam int unsigned IN_TDATA_W  = 216;
  localparam int unsigned OUT_TDATA_W = 288;
  localparam int unsigned COEF_W      = 48;

  // One accepted input beat, with its zero-duration class attached.
  typedef struct packed {
    logic               zero;
    logic signed [31:0] start_pos;
    logic signed [31:0] start_vel;
    logic signed [31:0] start_acc;
    logic signed [31:0] end_pos;
    logic signed [31:0] end_vel;
    logic signed [31:0] end_acc;
    logic        [23:0] duration;
  } item_t;

  // Head of the queue between the front and the back.
  typedef struct packed {
    logic  vld;
    item_t item;
  } fq_head_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef struct packed {
    status_t                   status;
    logic signed [COEF_W-1:0]  coef_five;
    logic signed [COEF_W-1:0]  coef_four;
    logic signed [COEF_W-1:0]  coef_three;
    logic signed [COEF_W-1:0]  coef_two;
    logic signed [COEF_W-1:0]  coef_one;
    logic signed [COEF_W-1:0]  coef_zero;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mjq_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Two-stage signed multiplier: 25x25 partial products are registered, then summed.
module mjq_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 25
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [AW-1:0]      a,
  input  logic signed [BW-1:0]      b,
  output logic signed [AW+BW-1:0]   p
);

  localparam int unsigned CW  = 24;
  localparam int unsigned NA  = (AW + CW - 1) / CW;
  localparam int unsigned NB  = (BW + CW - 1) / CW;
  localparam int unsigned AXW = NA * CW;
  localparam int unsigned BXW = NB * CW;
  localparam int unsigned SW  = (NA + NB) * CW + 2;
  localparam int unsigned PW  = AW + BW;

  logic signed [AXW-1:0]  ax;
  logic signed [BXW-1:0]  bx;
  logic signed [CW:0]     ac [NA];
  logic signed [CW:0]     bc [NB];
  logic signed [2*CW+1:0] pp_r [NA][NB];
  logic signed [SW-1:0]   acc;
  logic signed [PW-1:0]   p_r;

  assign ax = AXW'(a);
  assign bx = BXW'(b);

  // Lower chunks are unsigned; the top chunk carries the sign.
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      if (i == NA - 1) begin
        ac[i] = $signed({ax[i*CW+CW-1], ax[i*CW +: CW]});
      end else begin
        ac[i] = $signed({1'b0, ax[i*CW +: CW]});
      end
    end
    for (int j = 0; j < NB; j++) begin
      if (j == NB - 1) begin
        bc[j] = $signed({bx[j*CW+CW-1], bx[j*CW +: CW]});
      end else begin
        bc[j] = $signed({1'b0, bx[j*CW +: CW]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= ac[i] * bc[j];
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (SW'(pp_r[i][j]) <<< (CW * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= acc[PW-1:0];
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

// ----- hw/rtl/mjq_div.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage. The first stage flags
// quotients of 2^QW or more; below that the QW stages give the exact quotient.
module mjq_div #(
  parameter int unsigned NW = 121,
  parameter int unsigned DW = 73,
  parameter int unsigned QW = 48
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] q,
  output logic          big
);

  localparam int unsigned RW = (NW > DW + QW) ? NW : DW + QW;

  logic [RW-1:0] r_r   [0:QW];
  logic [DW-1:0] dn_r  [0:QW];
  logic [QW-1:0] q_r   [0:QW];
  logic          big_r [0:QW];
  logic [RW-1:0] sh    [0:QW-1];
  logic          ge    [0:QW-1];

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      sh[k] = RW'(dn_r[k]) << (QW - 1 - k);
      ge[k] = r_r[k] >= sh[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= RW'(num);
      dn_r[0]  <= den;
      q_r[0]   <= '0;
      big_r[0] <= RW'(num) >= (RW'(den) << QW);
      for (int k = 0; k < QW; k++) begin
        r_r[k+1]   <= ge[k] ? r_r[k] - sh[k] : r_r[k];
        dn_r[k+1]  <= dn_r[k];
        big_r[k+1] <= big_r[k];
        q_r[k+1]   <= q_r[k] | (ge[k] ? (QW'(1) << (QW - 1 - k)) : QW'(0));
      end
    end
  end

  assign q   = q_r[QW];
  assign big = big_r[QW];

endmodule

`default_nettype wire

// ----- hw/rtl/mjq_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Input side: unpacks the beat, marks zero-duration items and queues them.
module mjq_front #(
  parameter int unsigned DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [mjq_pkg::IN_TDATA_W-1:0]    in_tdata,
  output mjq_pkg::fq_head_t                 head,
  input  logic                              pop
);

  import mjq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t          mem_r [DEPTH];
  item_t          in_item;
  logic [AW-1:0]  wp_r;
  logic [AW-1:0]  rp_r;
  logic [CW-1:0]  cnt_r;
  logic           push;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] ptr);
    return (ptr == AW'(DEPTH - 1)) ? AW'(0) : ptr + AW'(1);
  endfunction

  always_comb begin
    in_item.start_pos = in_tdata[31:0];
    in_item.start_vel = in_tdata[63:32];
    in_item.start_acc = in_tdata[95:64];
    in_item.end_pos   = in_tdata[127:96];
    in_item.end_vel   = in_tdata[159:128];
    in_item.end_acc   = in_tdata[191:160];
    in_item.duration  = in_tdata[215:192];
    in_item.zero      = (in_tdata[215:192] == 24'd0);
  end

  assign in_tready = (cnt_r != CW'(DEPTH));
  assign push      = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wrap_inc(wp_r);
      end
      if (pop) begin
        rp_r <= wrap_inc(rp_r);
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  assign head.vld  = (cnt_r != '0);
  assign head.item = mem_r[rp_r];

endmodule

`default_nettype wire

// ----- hw/rtl/mjq_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Arithmetic pipeline: powers of T, the three numerators, rounding division
// and saturation. All stages advance together on en.
module mjq_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mjq_pkg::fq_head_t   head,
  output logic                pop,
  output logic                out_vld,
  input  logic                out_rdy,
  output mjq_pkg::result_t    res
);

  import mjq_pkg::*;

  localparam int unsigned QW      = 48;
  localparam int unsigned DIV_LAT = QW + 1;
  localparam int unsigned NST     = 9 + DIV_LAT + 1;
  localparam int unsigned NW      = 89;
  localparam int unsigned MW      = 88;

  localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  typedef struct packed {
    logic              zero;
    logic [COEF_W-1:0] c0;
    logic [COEF_W-1:0] c1;
    logic [COEF_W-1:0] c2;
  } side_t;

  logic               en;
  logic [NST:1]       v_r;
  side_t              side_r [1:NST-1];
  logic [2:0]         negd_r [8:NST-1];

  logic        [23:0] d_r  [1:5];
  logic signed [24:0] ds1, ds3, ds4, ds5;
  logic signed [31:0] vs1_r;
  logic signed [31:0] as_r [1:3];
  logic signed [32:0] dp_r [1:3];
  logic signed [32:0] dv_r [1:3];
  logic signed [32:0] da_r [1:3];

  logic signed [49:0]  d2_p;
  logic signed [48:0]  d2s;
  logic signed [56:0]  vd_p, ad_p;
  logic signed [73:0]  d3_p;
  logic signed [97:0]  d4_p;
  logic signed [96:0]  d4s;
  logic signed [80:0]  asd2_p;
  logic signed [81:0]  dad2_p;
  logic signed [57:0]  dvn_r;
  logic signed [74:0]  hp_r [4:5];
  logic signed [82:0]  dvd_p;
  logic signed [121:0] d5_p;
  logic signed [81:0]  h_r, dad2_r;
  logic        [71:0]  d3_r [6:8];
  logic        [95:0]  d4_r [6:8];
  logic        [119:0] d5_r;

  logic signed [NW-1:0] hx, vx, ax;
  logic signed [NW-1:0] n3_r, n4_r, n5_r;
  logic signed [NW-1:0] nn3, nn4, nn5;
  logic [MW-1:0]        mag3_r, mag4_r, mag5_r;
  logic [120:0]         num3_r;
  logic [136:0]         num4_r;
  logic [152:0]         num5_r;
  logic [72:0]          den3_r;
  logic [96:0]          den4_r;
  logic [120:0]         den5_r;

  logic [QW-1:0] q3, q4, q5;
  logic          big3, big4, big5;
  logic [COEF_W:0] f3, f4, f5;
  result_t       res_r;
  result_t       res_nxt;

  assign en      = !v_r[NST] || out_rdy;
  assign pop     = en && head.vld;
  assign out_vld = v_r[NST];
  assign res     = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-1:1], head.vld};
    end
  end

  // Stage 1: capture, differences and the three exact coefficients.
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[1].zero <= head.item.zero;
      side_r[1].c0   <= {head.item.start_pos, 16'b0};
      side_r[1].c1   <= {head.item.start_vel, 16'b0};
      side_r[1].c2   <= {head.item.start_acc[31], head.item.start_acc, 15'b0};
      for (int k = 2; k < NST; k++) begin
        side_r[k] <= side_r[k-1];
      end
      d_r[1]  <= head.item.duration;
      vs1_r   <= head.item.start_vel;
      as_r[1] <= head.item.start_acc;
      dp_r[1] <= {head.item.end_pos[31], head.item.end_pos}
               - {head.item.start_pos[31], head.item.start_pos};
      dv_r[1] <= {head.item.end_vel[31], head.item.end_vel}
               - {head.item.start_vel[31], head.item.start_vel};
      da_r[1] <= {head.item.end_acc[31], head.item.end_acc}
               - {head.item.start_acc[31], head.item.start_acc};
      for (int k = 2; k <= 5; k++) begin
        d_r[k] <= d_r[k-1];
      end
      for (int k = 2; k <= 3; k++) begin
        as_r[k] <= as_r[k-1];
        dp_r[k] <= dp_r[k-1];
        dv_r[k] <= dv_r[k-1];
        da_r[k] <= da_r[k-1];
      end
    end
  end

  assign ds1 = {1'b0, d_r[1]};
  assign ds3 = {1'b0, d_r[3]};
  assign ds4 = {1'b0, d_r[4]};
  assign ds5 = {1'b0, d_r[5]};
  assign d2s = d2_p[48:0];
  assign d4s = d4_p[96:0];

  mjq_mul #(.AW(25), .BW(25)) u_d2   (.clk, .en, .a(ds1),      .b(ds1), .p(d2_p));
  mjq_mul #(.AW(32), .BW(25)) u_vd   (.clk, .en, .a(vs1_r),    .b(ds1), .p(vd_p));
  mjq_mul #(.AW(32), .BW(25)) u_ad   (.clk, .en, .a(as_r[1]),  .b(ds1), .p(ad_p));
  mjq_mul #(.AW(49), .BW(25)) u_d3   (.clk, .en, .a(d2s),      .b(ds3), .p(d3_p));
  mjq_mul #(.AW(49), .BW(49)) u_d4   (.clk, .en, .a(d2s),      .b(d2s), .p(d4_p));
  mjq_mul #(.AW(32), .BW(49)) u_asd2 (.clk, .en, .a(as_r[3]),  .b(d2s), .p(asd2_p));
  mjq_mul #(.AW(33), .BW(49)) u_dad2 (.clk, .en, .a(da_r[3]),  .b(d2s), .p(dad2_p));
  mjq_mul #(.AW(58), .BW(25)) u_dvd  (.clk, .en, .a(dvn_r),    .b(ds4), .p(dvd_p));
  mjq_mul #(.AW(97), .BW(25)) u_d5   (.clk, .en, .a(d4s),      .b(ds5), .p(d5_p));

  // Stages 4 to 7: position gap h (x2^49), velocity gap (x2^32), accel gap (x2^16).
  always_comb begin
    hx  = NW'(h_r);
    vx  = NW'(dvd_p);
    ax  = NW'(dad2_r);
    nn3 = -n3_r;
    nn4 = -n4_r;
    nn5 = -n5_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvn_r   <= (58'(dv_r[3]) <<< 16) - 58'(ad_p);
      hp_r[4] <= (75'(dp_r[3]) <<< 33) - (75'(vd_p) <<< 17);
      hp_r[5] <= hp_r[4];
      h_r     <= 82'(hp_r[5]) - 82'(asd2_p);
      dad2_r  <= dad2_p;
      d3_r[6] <= d3_p[71:0];
      d4_r[6] <= d4_p[95:0];
      d3_r[7] <= d3_r[6];
      d4_r[7] <= d4_r[6];
      d3_r[8] <= d3_r[7];
      d4_r[8] <= d4_r[7];
      d5_r    <= d5_p[119:0];
      n3_r    <= (hx <<< 3) + (hx <<< 1) - (vx <<< 3) + ax;
      n4_r    <= hx - (hx <<< 4) + (vx <<< 4) - (vx <<< 1) - (ax <<< 1);
      n5_r    <= (hx <<< 2) + (hx <<< 1) - (vx <<< 2) - (vx <<< 1) + ax;
      // Stage 8: sign and magnitude.
      negd_r[8] <= {n5_r[NW-1], n4_r[NW-1], n3_r[NW-1]};
      for (int k = 9; k < NST; k++) begin
        negd_r[k] <= negd_r[k-1];
      end
      mag3_r <= n3_r[NW-1] ? nn3[MW-1:0] : n3_r[MW-1:0];
      mag4_r <= n4_r[NW-1] ? nn4[MW-1:0] : n4_r[MW-1:0];
      mag5_r <= n5_r[NW-1] ? nn5[MW-1:0] : n5_r[MW-1:0];
      // Stage 9: rounding numerator mag*2^(s+1) + T^k over 2*T^k.
      num3_r <= 121'({mag3_r, 32'b0}) + 121'(d3_r[8]);
      num4_r <= 137'({mag4_r, 48'b0}) + 137'(d4_r[8]);
      num5_r <= 153'({mag5_r, 64'b0}) + 153'(d5_r);
      den3_r <= {d3_r[8], 1'b0};
      den4_r <= {d4_r[8], 1'b0};
      den5_r <= {d5_r, 1'b0};
    end
  end

  mjq_div #(.NW(121), .DW(73),  .QW(QW)) u_div3
    (.clk, .en, .num(num3_r), .den(den3_r), .q(q3), .big(big3));
  mjq_div #(.NW(137), .DW(97),  .QW(QW)) u_div4
    (.clk, .en, .num(num4_r), .den(den4_r), .q(q4), .big(big4));
  mjq_div #(.NW(153), .DW(121), .QW(QW)) u_div5
    (.clk, .en, .num(num5_r), .den(den5_r), .q(q5), .big(big5));

  // Returns {saturated, coefficient}.
  function automatic logic [COEF_W:0] fix_coef(input logic [QW-1:0] q,
                                               input logic big, input logic neg);
    logic [COEF_W:0] r;
    if (!neg) begin
      if (big || q[QW-1]) begin
        r = {1'b1, COEF_MAX};
      end else begin
        r = {1'b0, q};
      end
    end else begin
      if (big || (q > COEF_MIN)) begin
        r = {1'b1, COEF_MIN};
      end else begin
        r = {1'b0, -q};
      end
    end
    return r;
  endfunction

  always_comb begin
    f3 = fix_coef(q3, big3, negd_r[NST-1][0]);
    f4 = fix_coef(q4, big4, negd_r[NST-1][1]);
    f5 = fix_coef(q5, big5, negd_r[NST-1][2]);
    if (side_r[NST-1].zero) begin
      res_nxt        = '0;
      res_nxt.status = ST_ZERO;
    end else begin
      res_nxt.coef_zero  = side_r[NST-1].c0;
      res_nxt.coef_one   = side_r[NST-1].c1;
      res_nxt.coef_two   = side_r[NST-1].c2;
      res_nxt.coef_three = f3[COEF_W-1:0];
      res_nxt.coef_four  = f4[COEF_W-1:0];
      res_nxt.coef_five  = f5[COEF_W-1:0];
      res_nxt.status     = (f3[COEF_W] || f4[COEF_W] || f5[COEF_W]) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/min_jerk_quintic_solver.sv -----
// An accepted input beat goes through the queue and then every back stage; a
//   stall on the result side holds the whole back pipeline.
// Throughput: one beat per cycle without result-side stalls; the pipeline of
//   split multipliers and three bit-per-cycle dividers sets latency, not rate.
// Reset (rst_n low, synchronous) empties the input queue and clears every
//   pipeline valid bit; data registers keep whatever they held.
`timescale 1ns / 1ps
`default_nettype none

module min_jerk_quintic_solver #(
  parameter int unsigned FIFO_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // From bit 0: start_pos[31:0], start_vel[31:0], start_acc[31:0], end_pos[31:0],
  // end_vel[31:0], end_acc[31:0], duration[23:0].
  input  logic [mjq_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // From bit 0: coef_zero, coef_one, coef_two, coef_three, coef_four,
  // coef_five, 48 bits each.
  output logic [mjq_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // Bits 1:0: status (0 ok, 1 zero duration, 2 saturated).
  output logic [1:0]                        out_tuser
);

  import mjq_pkg::*;

  // The front takes beats, flags zero durations and queues them. The queue lets
  // input beats keep arriving while a finished result waits to be taken.
  fq_head_t head;
  logic     pop;
  result_t  res;

  mjq_front #(.DEPTH(FIFO_DEPTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .head      (head),
    .pop       (pop)
  );

  // The back is one lock-step pipeline. It advances whenever its output register
  // is empty or being drained, so it pops the queue once per cycle in steady
  // state. Coefficients a3..a5 are the exact rational values rounded to the
  // nearest Q16.32 step, ties away from zero, and clamped to 48 bits.
  mjq_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .pop     (pop),
    .out_vld (out_tvalid),
    .out_rdy (out_tready),
    .res     (res)
  );

  assign out_tdata = {res.coef_five, res.coef_four, res.coef_three,
                      res.coef_two, res.coef_one, res.coef_zero};
  assign out_tuser = res.status;

  // A zero duration always comes out as six zero coefficients.
  a_zero_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == ST_ZERO) |-> (out_tdata == '0))
    else $error("zero-duration result carries nonzero coefficients");

  // The exact coefficients are Q16.16 inputs moved up into Q16.32, the quadratic one halved.
  a_low_coef_align: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_ZERO) |->
      (out_tdata[15:0] == 16'd0 && out_tdata[63:48] == 16'd0
       && out_tdata[110:96] == 15'd0))
    else $error("constant, linear or quadratic coefficient misaligned");

endmodule

`default_nettype wire
